@@ design/ctu_pkg.sv @@
// Shared constants and the arctangent table for the cylinder unwrap transform.
package ctu_pkg;

  localparam int SCALE_BITS  = 20;
  localparam int ATAN_LEN    = 32;
  localparam int SQRT_STAGES = 33;
  localparam int RAD_W       = 66;
  localparam int ROOT_W      = 33;
  localparam int REM_W       = 36;
  localparam int CX_W        = 56;
  localparam int Z_W         = 34;
  localparam int IDX_W       = 8;

  localparam logic [IDX_W-1:0] REG_CENTER_X = 8'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 8'd1;
  localparam logic [IDX_W-1:0] REG_OUTER    = 8'd2;

  // atan(2^-i) in Q2.30.
  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  localparam logic [Z_W-1:0] HALF_TURN_Z = {2'b00, ATAN_Q30[0]} << 1;
  localparam logic [32:0]    FULL_PI_Q30 = {1'b0, ATAN_Q30[0]} << 2;

  typedef struct packed {
    logic dy_zero;
    logic dx_neg;
    logic dy_pos;
  } ctu_flags_t;

endpackage

@@ design/cylinder_unwrap_transform.sv @@
// Top level of the cylinder unwrap transform: radius, angle and unrolled point.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid/s_axis_tready    point_x, point_y
//   m_axis    out        m_axis_tvalid/m_axis_tready    flat_x, flat_y, saturated
//   cfg       in         cfg_we                         cfg_index, cfg_data
//
// One request enters per cycle while the output is not stalled; the path to the
// output register is set by the 33-stage square root; the CORDIC runs alongside.
// Reset clears the valid bits and loads the register defaults.
// A stall on the output freezes the whole pipeline; nothing is dropped or doubled.
module cylinder_unwrap_transform import ctu_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,  // point_x [31:0], point_y [63:32]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // flat_x [31:0], flat_y [63:32]
  output logic             m_axis_tuser,  // saturated [0]
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int ZDLY = SQRT_STAGES + 2 - CORDIC_STEPS;
  localparam int FDLY = SQRT_STAGES + 2;
  localparam int NV   = SQRT_STAGES + 6;

  logic en;
  logic [NV-1:0] vld;

  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [30:0]        outer_radius;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      center_x     <= '0;
      center_y     <= '0;
      outer_radius <= 31'd655360;
    end else begin
      if (en) vld <= {vld[NV-2:0], s_axis_tvalid};
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CENTER_X: center_x     <= cfg_data;
          REG_CENTER_Y: center_y     <= cfg_data;
          REG_OUTER:    outer_radius <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  // Offsets from the axis.
  logic signed [32:0] dx, dy;
  always_ff @(posedge clk) begin
    if (en) begin
      dx <= $signed({s_axis_tdata[31], s_axis_tdata[31:0]}) - $signed({center_x[31], center_x});
      dy <= $signed({s_axis_tdata[63], s_axis_tdata[63:32]}) - $signed({center_y[31], center_y});
    end
  end

  // Magnitudes, special-case flags and the quarter-turn pre-rotation.
  logic [31:0]            ax, ay;
  ctu_flags_t             flags;
  logic signed [CX_W-1:0] cx0, cy0;
  logic signed [Z_W-1:0]  cz0;
  logic signed [CX_W-1:0] sx, sy;
  logic signed [32:0]     ndx, ndy;

  always_comb begin
    sx  = $signed({{(CX_W-33-SCALE_BITS){dx[32]}}, dx, {SCALE_BITS{1'b0}}});
    sy  = $signed({{(CX_W-33-SCALE_BITS){dy[32]}}, dy, {SCALE_BITS{1'b0}}});
    ndx = -dx;
    ndy = -dy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= dx[32] ? ndx[31:0] : dx[31:0];
      ay <= dy[32] ? ndy[31:0] : dy[31:0];
      flags.dy_zero <= (dy == '0);
      flags.dx_neg  <= dx[32];
      flags.dy_pos  <= !dy[32] && (dy != '0);
      if (dx[32]) begin
        if (!dy[32]) begin
          cx0 <= sy;
          cy0 <= -sx;
          cz0 <= $signed(HALF_TURN_Z);
        end else begin
          cx0 <= -sy;
          cy0 <= sx;
          cz0 <= -$signed(HALF_TURN_Z);
        end
      end else begin
        cx0 <= sx;
        cy0 <= sy;
        cz0 <= '0;
      end
    end
  end

  logic [63:0]      sx2, sy2;
  logic [RAD_W-1:0] rad;
  always_ff @(posedge clk) begin
    if (en) begin
      sx2 <= {32'd0, ax} * {32'd0, ax};
      sy2 <= {32'd0, ay} * {32'd0, ay};
      rad <= {1'b0, {1'b0, sx2} + {1'b0, sy2}};
    end
  end

  logic [ROOT_W-1:0] d_root;
  ctu_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (d_root)
  );

  logic signed [Z_W-1:0] z_rot;
  ctu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .en    (en),
    .x_in  (cx0),
    .y_in  (cy0),
    .z_in  (cz0),
    .z_out (z_rot)
  );

  logic signed [Z_W-1:0] zd [ZDLY];
  ctu_flags_t            fd [FDLY];
  always_ff @(posedge clk) begin
    if (en) begin
      zd[0] <= z_rot;
      for (int k = 1; k < ZDLY; k++) zd[k] <= zd[k-1];
      fd[0] <= flags;
      for (int k = 1; k < FDLY; k++) fd[k] <= fd[k-1];
    end
  end

  // Angle magnitude rounded to Q2.28, then scaled by the radius.
  ctu_flags_t        fl_end;
  logic [Z_W-1:0]    zabs;
  logic [32:0]       mag30;
  logic [33:0]       mag_rnd;
  logic [30:0]       mag28;
  always_comb begin
    fl_end  = fd[FDLY-1];
    zabs    = zd[ZDLY-1][Z_W-1] ? Z_W'(-zd[ZDLY-1]) : Z_W'(zd[ZDLY-1]);
    if (fl_end.dy_zero) mag30 = fl_end.dx_neg ? FULL_PI_Q30 : 33'd0;
    else                mag30 = zabs[32:0];
    mag_rnd = {1'b0, mag30} + 34'd2;
    mag28   = mag_rnd[32:2];
  end

  logic [63:0]       prod;
  logic [ROOT_W-1:0] dist_p;
  logic              dy_pos_p;
  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= {31'd0, d_root} * {33'd0, mag28};
      dist_p   <= d_root;
      dy_pos_p <= fl_end.dy_pos;
    end
  end

  logic [64:0]        prod_rnd;
  logic signed [39:0] term, fx_w, fy_w;
  logic               sat_x_hi, sat_x_lo, sat_y_hi, sat_y_lo;
  always_comb begin
    prod_rnd = {1'b0, prod} + 65'h8000000;
    term     = $signed({3'b000, prod_rnd[64:28]});
    fx_w     = (dy_pos_p ? term : -term) + 40'(center_x);
    fy_w     = $signed({9'd0, outer_radius}) + 40'(center_y)
             - $signed({7'd0, dist_p});
    sat_x_hi = fx_w > 40'sh007FFFFFFF;
    sat_x_lo = fx_w < -40'sh0080000000;
    sat_y_hi = fy_w > 40'sh007FFFFFFF;
    sat_y_lo = fy_w < -40'sh0080000000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata[31:0]  <= sat_x_hi ? 32'h7FFFFFFF : sat_x_lo ? 32'h80000000 : fx_w[31:0];
      m_axis_tdata[63:32] <= sat_y_hi ? 32'h7FFFFFFF : sat_y_lo ? 32'h80000000 : fy_w[31:0];
      m_axis_tuser        <= sat_x_hi || sat_x_lo || sat_y_hi || sat_y_lo;
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |=> $stable(vld))
    else $error("pipeline moved during a stall");
  a_accept_travels: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted request not captured");

endmodule

@@ design/ctu_sqrt.sv @@
// Pipelined restoring integer square root, one result bit per stage.
module ctu_sqrt import ctu_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  logic [REM_W-1:0]  rem_s  [0:SQRT_STAGES];
  logic [ROOT_W-1:0] root_s [0:SQRT_STAGES];
  logic [RAD_W-1:0]  rad_s  [0:SQRT_STAGES];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
    localparam int PI = SQRT_STAGES - 1 - k;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    always_comb begin
      shifted = {rem_s[k][REM_W-3:0], rad_s[k][2*PI+1 -: 2]};
      trial   = {1'b0, root_s[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[k+1] <= rad_s[k];
        if (shifted >= trial) begin
          rem_s[k+1]  <= shifted - trial;
          root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem_s[k+1]  <= shifted;
          root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_s[SQRT_STAGES];

endmodule

@@ design/ctu_cordic.sv @@
// Pipelined vectoring CORDIC, one micro-rotation per stage, angle out in Q2.30.
module ctu_cordic import ctu_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [CX_W-1:0] x_in,
  input  logic signed [CX_W-1:0] y_in,
  input  logic signed [Z_W-1:0]  z_in,
  output logic signed [Z_W-1:0]  z_out
);

  logic signed [CX_W-1:0] x_s [0:CORDIC_STEPS];
  logic signed [CX_W-1:0] y_s [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_s [0:CORDIC_STEPS];

  assign x_s[0] = x_in;
  assign y_s[0] = y_in;
  assign z_s[0] = z_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic signed [Z_W-1:0]  ang;
    always_comb begin
      xs  = x_s[i] >>> i;
      ys  = y_s[i] >>> i;
      ang = $signed({2'b00, ATAN_Q30[i]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_s[i] > 0) begin
          x_s[i+1] <= x_s[i] + ys;
          y_s[i+1] <= y_s[i] - xs;
          z_s[i+1] <= z_s[i] + ang;
        end else begin
          x_s[i+1] <= x_s[i] - ys;
          y_s[i+1] <= y_s[i] + xs;
          z_s[i+1] <= z_s[i] - ang;
        end
      end
    end
  end

  assign z_out = z_s[CORDIC_STEPS];

endmodule
